// ----- rtl/core/bdlp_pkg.sv -----
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int NB      = 16;
    localparam int IDX_W   = $clog2(NB);
    localparam int CNT_W   = 16;
    localparam int DEB_W   = 10;
    localparam int SEL_W   = 5;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    localparam logic [CFG_A_W-1:0] CFG_ACTIVE_HIGH = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_LONG_CAP    = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_DEBOUNCE    = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_HOLD        = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_SHIFT_SEL   = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_SHIFTED     = 3'd5;

    localparam logic [DEB_W-1:0] DEB_RESET  = 10'd50;
    localparam logic [CNT_W-1:0] HOLD_RESET = 16'd1000;
    localparam logic [SEL_W-1:0] SEL_NONE   = SEL_W'(NB);

    typedef struct packed {
        logic [NB-1:0]    active_high;
        logic [NB-1:0]    long_cap;
        logic [DEB_W-1:0] debounce;
        logic [CNT_W-1:0] hold;
        logic [SEL_W-1:0] shift_sel;
        logic [NB-1:0]    shifted;
    } t_cfg;

    // new per-button state after one visit
    typedef struct packed {
        logic             last_raw;
        logic [CNT_W-1:0] cnt;
        logic             run;
        logic             stable;
        logic             lp;
    } t_upd;

    typedef struct packed {
        logic vld;
        logic pair;
        logic pressed;
        logic shifted;
        logic long_flag;
    } t_ev_req;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             pressed;
        logic             shifted;
        logic             long_flag;
    } t_event;

endpackage

// ----- rtl/core/bdlp_in_if.sv -----
`timescale 1ns / 1ps

interface bdlp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink (input valid, input raw_levels, output ready);
endinterface

// ----- rtl/core/bdlp_out_if.sv -----
`timescale 1ns / 1ps

interface bdlp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] button_index;
    logic       pressed;
    logic       shifted;
    logic       long_flag;
    logic       last;

    modport source (output valid, output button_index, output pressed, output shifted,
                    output long_flag, output last, input ready);
    modport sink (input valid, input button_index, input pressed, input shifted,
                  input long_flag, input last, output ready);
endinterface

// ----- rtl/core/bdlp_eval.sv -----
`timescale 1ns / 1ps

module bdlp_eval (
    input  logic [bdlp_pkg::IDX_W-1:0] i_idx,
    input  logic                       i_raw_bit,
    input  logic                       i_last_raw,
    input  logic [bdlp_pkg::CNT_W-1:0] i_cnt,
    input  logic                       i_run,
    input  logic                       i_lp,
    input  logic [bdlp_pkg::NB-1:0]    i_stable,
    input  logic [bdlp_pkg::NB-1:0]    i_su,
    input  bdlp_pkg::t_cfg             i_cfg,
    output bdlp_pkg::t_upd             o_upd,
    output logic [bdlp_pkg::NB-1:0]    o_su,
    output bdlp_pkg::t_ev_req          o_ev
);
    import bdlp_pkg::*;

    logic [CNT_W-1:0] deb;
    logic [CNT_W-1:0] hold;
    logic             shv;
    logic [IDX_W-1:0] sb;
    logic [NB-1:0]    stable_new;
    logic             sh;
    logic             shf;
    logic             lcap;
    logic             pi;
    logic [NB-1:0]    su_mid;

    assign deb  = (i_cfg.debounce == '0) ? CNT_W'(1) : CNT_W'(i_cfg.debounce);
    assign hold = (i_cfg.hold == '0) ? CNT_W'(1) : i_cfg.hold;
    assign shv  = (i_cfg.shift_sel < SEL_NONE);
    assign sb   = i_cfg.shift_sel[IDX_W-1:0];

    always_comb begin
        stable_new        = i_stable;
        stable_new[i_idx] = i_raw_bit;
    end

    // shift state is seen after this button's own level update
    assign shf  = shv && i_cfg.shifted[i_idx];
    assign sh   = shf && (stable_new[sb] == i_cfg.active_high[sb]);
    assign lcap = i_cfg.long_cap[i_idx] ||
                  (shv && (i_idx == sb) && (i_cfg.shifted != '0));
    assign pi   = (i_raw_bit == i_cfg.active_high[i_idx]);

    always_comb begin
        su_mid = i_su;
        if (sh) begin
            su_mid[sb] = 1'b1;
        end
    end

    always_comb begin
        o_upd = '{last_raw: i_last_raw, cnt: i_cnt, run: i_run,
                  stable: i_stable[i_idx], lp: i_lp};
        o_su  = i_su;
        o_ev  = '0;
        priority if (i_raw_bit != i_last_raw) begin
            o_upd.last_raw = i_raw_bit;
            o_upd.cnt      = deb;
            o_upd.run      = 1'b1;
        end else if (!i_run) begin
            o_upd.run = 1'b0;
        end else if (i_cnt > CNT_W'(1)) begin
            o_upd.cnt = i_cnt - CNT_W'(1);
        end else begin
            // countdown expired
            o_upd.cnt    = '0;
            o_upd.run    = 1'b0;
            o_upd.stable = i_raw_bit;
            o_su         = su_mid;
            if (lcap && !i_lp && pi) begin
                o_upd.lp  = 1'b1;
                o_upd.cnt = hold;
                o_upd.run = 1'b1;
            end else begin
                o_upd.lp = 1'b0;
                if (i_lp) begin
                    if (!pi) begin
                        if (!su_mid[i_idx]) begin
                            o_ev = '{vld: 1'b1, pair: 1'b1, pressed: 1'b1,
                                     shifted: sh, long_flag: 1'b0};
                        end
                        o_su[i_idx] = 1'b0;
                    end else if (!su_mid[i_idx]) begin
                        o_ev = '{vld: 1'b1, pair: 1'b0, pressed: 1'b1,
                                 shifted: sh, long_flag: 1'b1};
                    end
                end else begin
                    if (!su_mid[i_idx]) begin
                        o_ev = '{vld: 1'b1, pair: 1'b0, pressed: pi,
                                 shifted: sh, long_flag: lcap};
                    end
                    o_su[i_idx] = 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/core/button_debounce_long_press_shift_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  payload                                         handshake
// i_item    in         raw_levels[15:0]                                 valid/ready
// o_event   out        button_index, pressed, shifted, long_flag, last  valid/ready
// cfg       in         i_cfg_idx[2:0], i_cfg_data[15:0]                 i_cfg_we
//
// a tick is walked by the sequencer, visiting the 16 buttons one per cycle through the shared
// evaluator unless the output stalls, with an extra release step per early press+release pair
// each event waits in a one-deep holding register so the tick's final event can carry last
// a stalled output stops the button walk only when an event must move out
// synchronous active-low reset restores config defaults and per-button flags, not the counters

module button_debounce_long_press_shift_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bdlp_in_if.sink                       i_item,
    bdlp_out_if.source                    o_event,
    input  logic                          i_cfg_we,
    input  logic [bdlp_pkg::CFG_A_W-1:0]  i_cfg_idx,
    input  logic [bdlp_pkg::CFG_D_W-1:0]  i_cfg_data
);
    import bdlp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_PAIR2 = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_cfg             r_cfg;
    logic [NB-1:0]    r_raw;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [NB-1:0]    r_last_raw;
    logic [CNT_W-1:0] r_cnt [NB];
    logic [NB-1:0]    r_run;
    logic [NB-1:0]    r_stable;
    logic [NB-1:0]    r_lp;
    logic [NB-1:0]    r_su;
    logic             r_hold_vld, n_hold_vld;
    t_event           r_hold, n_hold;
    logic             r_out_vld, n_out_vld;
    t_event           r_out, n_out;
    logic             r_out_last, n_out_last;

    t_upd             upd;
    logic [NB-1:0]    su_next;
    t_ev_req          ev;
    logic             out_free;
    logic             commit;
    logic             last_btn;

    bdlp_eval u_eval (
        .i_idx      (r_idx),
        .i_raw_bit  (r_raw[r_idx]),
        .i_last_raw (r_last_raw[r_idx]),
        .i_cnt      (r_cnt[r_idx]),
        .i_run      (r_run[r_idx]),
        .i_lp       (r_lp[r_idx]),
        .i_stable   (r_stable),
        .i_su       (r_su),
        .i_cfg      (r_cfg),
        .o_upd      (upd),
        .o_su       (su_next),
        .o_ev       (ev)
    );

    assign out_free = !r_out_vld || o_event.ready;
    assign last_btn = (r_idx == IDX_W'(NB - 1));
    // an event can always go into an empty holding register
    assign commit   = (r_state == S_EVAL) && (!ev.vld || !r_hold_vld || out_free);

    assign i_item.ready         = (r_state == S_IDLE);
    assign o_event.valid        = r_out_vld;
    assign o_event.button_index = r_out.idx;
    assign o_event.pressed      = r_out.pressed;
    assign o_event.shifted      = r_out.shifted;
    assign o_event.long_flag    = r_out.long_flag;
    assign o_event.last         = r_out_last;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        n_out_vld  = r_out_vld && !o_event.ready;
        n_out      = r_out;
        n_out_last = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = S_EVAL;
                    n_idx   = '0;
                end
            end
            S_EVAL: begin
                if (commit) begin
                    if (ev.vld) begin
                        if (r_hold_vld) begin
                            n_out_vld  = 1'b1;
                            n_out      = r_hold;
                            n_out_last = 1'b0;
                        end
                        n_hold_vld = 1'b1;
                        n_hold     = '{idx: r_idx, pressed: ev.pressed,
                                       shifted: ev.shifted, long_flag: ev.long_flag};
                    end
                    priority if (ev.vld && ev.pair) begin
                        n_state = S_PAIR2;
                    end else if (last_btn) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_PAIR2: begin
                // early press+release pair: the held press goes out, the release stays held
                if (out_free) begin
                    n_out_vld         = 1'b1;
                    n_out             = r_hold;
                    n_out_last        = 1'b0;
                    n_hold.pressed    = 1'b0;
                    if (last_btn) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_EVAL;
                        n_idx   = r_idx + IDX_W'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out      = r_hold;
                    n_out_last = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (i_item.valid && i_item.ready) begin
            r_raw <= i_item.raw_levels;
        end
        if (commit) begin
            r_cnt[r_idx] <= upd.cnt;
        end
    end

    // per-button state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= '0;
            r_run      <= '0;
            r_stable   <= '1;
            r_lp       <= '0;
            r_su       <= '0;
        end else if (commit) begin
            r_last_raw[r_idx] <= upd.last_raw;
            r_run[r_idx]      <= upd.run;
            r_stable[r_idx]   <= upd.stable;
            r_lp[r_idx]       <= upd.lp;
            r_su              <= su_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_high <= '0;
            r_cfg.long_cap    <= '0;
            r_cfg.debounce    <= DEB_RESET;
            r_cfg.hold        <= HOLD_RESET;
            r_cfg.shift_sel   <= SEL_NONE;
            r_cfg.shifted     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE_HIGH: r_cfg.active_high <= i_cfg_data[NB-1:0];
                CFG_LONG_CAP:    r_cfg.long_cap    <= i_cfg_data[NB-1:0];
                CFG_DEBOUNCE:    r_cfg.debounce    <= i_cfg_data[DEB_W-1:0];
                CFG_HOLD:        r_cfg.hold        <= i_cfg_data[CNT_W-1:0];
                CFG_SHIFT_SEL:   r_cfg.shift_sel   <= i_cfg_data[SEL_W-1:0];
                CFG_SHIFTED:     r_cfg.shifted     <= i_cfg_data[NB-1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_vld)
        else $error("holding register not empty between ticks");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> ((r_state == S_EVAL) && (r_idx == '0)))
        else $error("tick did not start at button zero");

    a_pair_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR2) |-> r_hold_vld)
        else $error("pair release without held press");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && r_hold_vld && out_free)
        |=> ((r_state == S_IDLE) && r_out_vld && r_out_last))
        else $error("final event of tick not flagged last");
`endif

endmodule

// ----- tb/tb_button_debounce_long_press_shift_unit.sv -----
`timescale 1ns / 1ps

module tb_button_debounce_long_press_shift_unit;
    import bdlp_pkg::*;

    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             pressed;
        logic             shifted;
        logic             long_flag;
        logic             last;
    } t_button_event;

    localparam logic [15:0] DIRECTED_RAW [25] = '{
        16'hFFFE, 16'hFFFE, 16'hFFCE, 16'hFFCE, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFF,
        16'hFFFB, 16'hFFFB, 16'hFFFF, 16'hFFFF, 16'hFFF7, 16'hFFF7, 16'hFFF7, 16'hFFF7,
        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
        16'hFFFF
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_we;
    logic [CFG_A_W-1:0]  cfg_idx;
    logic [CFG_D_W-1:0]  cfg_data;

    bdlp_in_if  tick_ch ();
    bdlp_out_if event_ch ();

    button_debounce_long_press_shift_unit u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (tick_ch.sink),
        .o_event    (event_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // mirror of the block's configuration and per-button state
    t_cfg             model_cfg;
    logic [NB-1:0]    model_last_raw;
    logic [NB-1:0]    model_running;
    logic [NB-1:0]    model_stable;
    logic [NB-1:0]    model_long_pend;
    logic [NB-1:0]    model_shift_used;
    logic [CNT_W-1:0] model_count [NB];

    t_button_event due_events [$];
    int            n_mismatches = 0;
    bit            gaps_on = 1'b1;
    int            hold_off_reqs = 0;

    always #10 clk = ~clk;

    function automatic logic btn_pressed(input int b);
        return model_stable[b] == model_cfg.active_high[b];
    endfunction

    function automatic void clear_model();
        model_cfg = '{active_high: '0, long_cap: '0, debounce: DEB_RESET,
                      hold: HOLD_RESET, shift_sel: SEL_NONE, shifted: '0};
        model_last_raw   = '0;
        model_running    = '0;
        model_long_pend  = '0;
        model_shift_used = '0;
        model_stable     = ~model_cfg.active_high;
        for (int i = 0; i < NB; i++) model_count[i] = '0;
    endfunction

    // advance every button by one tick and queue the events it reports
    function automatic void debounce_tick(input logic [NB-1:0] raw);
        t_button_event    tick_events [$];
        t_button_event    ev;
        logic [CNT_W-1:0] deb;
        logic [CNT_W-1:0] hold;
        logic             sel_ok, shf, lcap, was_long, used, sh;
        int               sb;
        deb    = (model_cfg.debounce == '0) ? CNT_W'(1) : CNT_W'(model_cfg.debounce);
        hold   = (model_cfg.hold == '0) ? CNT_W'(1) : model_cfg.hold;
        sel_ok = model_cfg.shift_sel < NB;
        sb     = int'(model_cfg.shift_sel);
        for (int i = 0; i < NB; i++) begin
            if (raw[i] != model_last_raw[i]) begin
                model_last_raw[i] = raw[i];
                model_count[i]    = deb;
                model_running[i]  = 1'b1;
                continue;
            end
            if (!model_running[i]) continue;
            if (model_count[i] > 1) begin
                model_count[i]--;
                continue;
            end
            model_count[i]   = '0;
            model_running[i] = 1'b0;
            model_stable[i]  = raw[i];
            shf = sel_ok && model_cfg.shifted[i];
            if (shf && btn_pressed(sb)) model_shift_used[sb] = 1'b1;
            lcap = model_cfg.long_cap[i] ||
                   (sel_ok && i == sb && model_cfg.shifted != '0);
            // long-capable press: hold the event back and wait the hold time
            if (lcap && !model_long_pend[i] && btn_pressed(i)) begin
                model_long_pend[i] = 1'b1;
                model_count[i]     = hold;
                model_running[i]   = 1'b1;
                continue;
            end
            was_long           = model_long_pend[i];
            model_long_pend[i] = 1'b0;
            used               = model_shift_used[i];
            sh                 = shf && btn_pressed(sb);
            ev = '{idx: IDX_W'(i), pressed: 1'b0, shifted: sh, long_flag: 1'b0, last: 1'b0};
            if (was_long) begin
                if (!btn_pressed(i)) begin
                    // released before the hold time ran out
                    if (!used) begin
                        ev.pressed = 1'b1;
                        tick_events.push_back(ev);
                        ev.pressed = 1'b0;
                        tick_events.push_back(ev);
                    end
                    model_shift_used[i] = 1'b0;
                end else if (!used) begin
                    ev.pressed   = 1'b1;
                    ev.long_flag = 1'b1;
                    tick_events.push_back(ev);
                end
            end else begin
                if (!used) begin
                    ev.pressed   = btn_pressed(i);
                    ev.long_flag = lcap;
                    tick_events.push_back(ev);
                end
                model_shift_used[i] = 1'b0;
            end
        end
        if (tick_events.size() > 0) tick_events[$].last = 1'b1;
        foreach (tick_events[k]) due_events.push_back(tick_events[k]);
    endfunction

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE_HIGH: model_cfg.active_high = val[NB-1:0];
            CFG_LONG_CAP:    model_cfg.long_cap    = val[NB-1:0];
            CFG_DEBOUNCE:    model_cfg.debounce    = val[DEB_W-1:0];
            CFG_HOLD:        model_cfg.hold        = val[CNT_W-1:0];
            CFG_SHIFT_SEL:   model_cfg.shift_sel   = val[SEL_W-1:0];
            CFG_SHIFTED:     model_cfg.shifted     = val[NB-1:0];
            default: ;
        endcase
    endtask

    task automatic setup_all(input logic [15:0] ah, input logic [15:0] lp,
                             input logic [15:0] deb, input logic [15:0] hold,
                             input logic [15:0] sel, input logic [15:0] shm);
        write_reg(CFG_ACTIVE_HIGH, ah);
        write_reg(CFG_LONG_CAP, lp);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_HOLD, hold);
        write_reg(CFG_SHIFT_SEL, sel);
        write_reg(CFG_SHIFTED, shm);
    endtask

    task automatic offer_tick(input logic [15:0] raw);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 13) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.raw_levels <= raw;
        do @(posedge clk); while (!tick_ch.ready);
        debounce_tick(raw[NB-1:0]);
    endtask

    // block is idle once every event is out and the last tick walk has ended
    task automatic wait_idle();
        @(negedge clk);
        tick_ch.valid <= 1'b0;
        while (due_events.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // buttons held and released at random, with bounce and some noise ticks
    task automatic button_traffic(input int n_ticks);
        logic [NB-1:0] held;
        logic [15:0]   raw;
        held = $urandom_range(0, 1) ? NB'($urandom) : '0;
        for (int t = 0; t < n_ticks; t++) begin
            for (int b = 0; b < NB; b++)
                if ($urandom_range(0, 9) == 0) held[b] = ~held[b];
            raw = ~(model_cfg.active_high ^ held);
            if ($urandom_range(0, 9) == 0)
                raw = 16'($urandom);
            else if ($urandom_range(0, 4) == 0)
                raw ^= 16'(1) << $urandom_range(0, NB - 1);
            offer_tick(raw);
        end
    endtask

    task automatic test_reset_values();
        // default debounce of 50 ticks, then every button reports a release
        for (int t = 0; t < 52; t++) offer_tick(16'hFFFF);
        wait_idle();
    endtask

    task automatic test_directed_events();
        // shift on button 0 modifying 4 and 5, long-capable 2 and 3, active low
        setup_all(16'h0000, 16'h000C, 16'd1, 16'd2, 16'd0, 16'h0030);
        foreach (DIRECTED_RAW[k]) offer_tick(DIRECTED_RAW[k]);
        wait_idle();
    endtask

    task automatic test_zero_timers_no_shift();
        // zero debounce and hold act as one, shift index beyond the buttons
        setup_all(16'hA5A5, 16'hFFFF, 16'd0, 16'd0, 16'd31, 16'hFFFF);
        offer_tick(16'h0000);
        offer_tick(16'hFFFF);
        button_traffic(12);
        wait_idle();
        write_reg(CFG_SHIFT_SEL, 16'(NB));
        button_traffic(8);
        wait_idle();
    endtask

    task automatic test_max_timers();
        // upper buttons go into a long wait that will not run out here
        setup_all(16'h0000, 16'hFFFF, 16'd1, 16'hFFFF, 16'(NB), 16'h0000);
        offer_tick(16'h00FF);
        offer_tick(16'h00FF);
        offer_tick(16'h00FF);
        wait_idle();
        write_reg(CFG_DEBOUNCE, 16'd1023);
        for (int t = 0; t < 10; t++) offer_tick(t[0] ? 16'h0F0F : 16'hF0F0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 5; p++) begin
            if (p == 4)
                setup_all(16'hFFFF, 16'h0000, 16'd1, 16'd1, 16'd15, 16'h7FFF);
            else
                setup_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 4)),
                          16'($urandom_range(0, 8)), 16'($urandom_range(0, NB + 1)),
                          16'($urandom));
            gaps_on = (p != 3);
            if (p == 2) hold_off_reqs++;
            button_traffic(70);
            wait_idle();
        end
        gaps_on = 1'b1;
    endtask

    // event sink: random stalls plus requested long hold-offs
    initial begin : event_sink
        int hold_left;
        int seen_reqs;
        hold_left = 0;
        seen_reqs = 0;
        event_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (seen_reqs != hold_off_reqs) begin
                seen_reqs = hold_off_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                event_ch.ready <= 1'b0;
            end else begin
                event_ch.ready <= !gaps_on || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    always @(posedge clk) begin : event_check
        t_button_event got_ev;
        t_button_event exp_ev;
        if (rst_n && event_ch.valid && event_ch.ready) begin
            got_ev = '{idx: event_ch.button_index, pressed: event_ch.pressed,
                       shifted: event_ch.shifted, long_flag: event_ch.long_flag,
                       last: event_ch.last};
            if (due_events.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= 10)
                    $display("unexpected event: button %0d pressed %b shifted %b long %b last %b",
                             got_ev.idx, got_ev.pressed, got_ev.shifted, got_ev.long_flag,
                             got_ev.last);
            end else begin
                exp_ev = due_events.pop_front();
                if (got_ev !== exp_ev) begin
                    n_mismatches++;
                    if (n_mismatches <= 10)
                        $display({"event mismatch: expected button %0d pressed %b shifted %b ",
                                  "long %b last %b, got button %0d pressed %b shifted %b ",
                                  "long %b last %b"},
                                 exp_ev.idx, exp_ev.pressed, exp_ev.shifted,
                                 exp_ev.long_flag, exp_ev.last, got_ev.idx, got_ev.pressed,
                                 got_ev.shifted, got_ev.long_flag, got_ev.last);
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : test_sequence
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.raw_levels = '0;
        clear_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed_events();
        test_zero_timers_no_shift();
        test_max_timers();
        test_random_traffic();

        wait_idle();
        if (n_mismatches == 0 && due_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
